// ===== rtl/sliding_window_average_assert.svh =====
// Assertion macros shared by the moving-average RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SLIDING_WINDOW_AVERAGE_ASSERT_SVH
`define SLIDING_WINDOW_AVERAGE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define SWA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define SWA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SWA_ASSERT_IMP(lbl, ante, cons, msg)
`define SWA_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/swa_pkg.sv =====
`default_nettype none

package swa_pkg;

  // Sample width fixed by the stream format.
  localparam int SAMPLE_BITS = 24;

  // Width of the window length register.
  localparam int WL_BITS = 8;

  // Window length after reset.
  localparam logic [WL_BITS-1:0] WINDOW_RESET = 8'd100;

  // Configuration address width and register index.
  localparam int CFG_ADDR_BITS = 3;
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  // Input beat.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          last_sample;
  } in_beat_t;

  // Output beat.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] window_mean;
    logic                          warming_up;
  } out_beat_t;

  // Control carried alongside the data through the divider chain.
  typedef struct packed {
    logic valid;
    logic neg;
    logic warm;
  } div_ctrl_t;

  // Configuration write towards the window logic.
  typedef struct packed {
    logic               wr;
    logic [WL_BITS-1:0] value;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/swa_window.sv =====
`default_nettype none
`include "sliding_window_average_assert.svh"

module swa_window #(
  parameter int MAX_WINDOW = 128,
  localparam int CNT_BITS = $clog2(MAX_WINDOW + 1),
  localparam int PTR_BITS = $clog2(MAX_WINDOW),
  localparam int SUM_BITS = swa_pkg::SAMPLE_BITS + PTR_BITS
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  swa_pkg::cfg_wr_t                  cfg_i,
  output logic [swa_pkg::WL_BITS-1:0]       window_length_o,
  input  wire                               in_valid_i,
  input  wire                               adv_i,
  input  swa_pkg::in_beat_t                 in_data_i,
  output swa_pkg::div_ctrl_t                stage_ctrl_o,
  output logic signed [SUM_BITS-1:0]        stage_total_o,
  output logic [CNT_BITS-1:0]               stage_fill_o
);

  localparam int S = swa_pkg::SAMPLE_BITS;
  localparam int CMP_BITS = (CNT_BITS > swa_pkg::WL_BITS) ? CNT_BITS : swa_pkg::WL_BITS;

  // Clamp the programmed length into one to the depth of the delay line.
  function automatic logic [CNT_BITS-1:0] eff_len(input logic [swa_pkg::WL_BITS-1:0] wl);
    logic [CMP_BITS-1:0] wide;
    wide = CMP_BITS'(wl);
    if (wide == '0) begin
      return CNT_BITS'(1);
    end else if (wide > CMP_BITS'(MAX_WINDOW)) begin
      return CNT_BITS'(MAX_WINDOW);
    end else begin
      return CNT_BITS'(wide);
    end
  endfunction

  logic [swa_pkg::WL_BITS-1:0] wl_q, wl_d;
  logic signed [SUM_BITS-1:0]  total_q, total_d;
  logic [CNT_BITS-1:0]         fill_q, fill_d;
  logic [PTR_BITS-1:0]         wp_q, wp_d;
  logic [S-1:0]                rd_q;
  logic [PTR_BITS-1:0]         rd_addr_d;
  logic [PTR_BITS:0]           rd_sum;
  logic [S-1:0]                mem [MAX_WINDOW];

  logic                        accept;
  logic [CNT_BITS-1:0]         len_cur;
  logic                        full;
  logic signed [SUM_BITS:0]    sum_ext;
  logic signed [SUM_BITS-1:0]  total_new;
  logic [CNT_BITS-1:0]         fill_new;
  logic                        warm_new;
  logic [S-1:0]                smp;

  swa_pkg::div_ctrl_t          stage_ctrl_q, stage_ctrl_d;
  logic signed [SUM_BITS-1:0]  stage_total_q;
  logic [CNT_BITS-1:0]         stage_fill_q;

  assign accept  = in_valid_i && adv_i;
  assign smp     = in_data_i.sample_value;
  assign len_cur = eff_len(wl_q);
  assign full    = (fill_q >= len_cur);

  // Running sum update: add the new sample, drop the leaving one when full.
  always_comb begin
    sum_ext = {total_q[SUM_BITS-1], total_q} + {{(SUM_BITS + 1 - S){smp[S-1]}}, smp};
    if (full) begin
      sum_ext = sum_ext - {{(SUM_BITS + 1 - S){rd_q[S-1]}}, rd_q};
    end
    total_new = sum_ext[SUM_BITS-1:0];
    fill_new  = full ? fill_q : fill_q + CNT_BITS'(1);
    warm_new  = (fill_new < len_cur);
  end

  // Next state of the window registers.
  always_comb begin
    wl_d    = wl_q;
    total_d = total_q;
    fill_d  = fill_q;
    wp_d    = wp_q;
    if (cfg_i.wr) begin
      wl_d    = cfg_i.value;
      total_d = '0;
      fill_d  = '0;
    end else if (accept) begin
      wp_d = (wp_q == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : wp_q + PTR_BITS'(1);
      if (in_data_i.last_sample) begin
        total_d = '0;
        fill_d  = '0;
      end else begin
        total_d = total_new;
        fill_d  = fill_new;
      end
    end
  end

  // Slot of the sample that leaves the window with the next beat.
  always_comb begin
    rd_sum = {1'b0, wp_d} + (PTR_BITS + 1)'(MAX_WINDOW) - (PTR_BITS + 1)'(eff_len(wl_d));
    if (rd_sum >= (PTR_BITS + 1)'(MAX_WINDOW)) begin
      rd_sum = rd_sum - (PTR_BITS + 1)'(MAX_WINDOW);
    end
    rd_addr_d = rd_sum[PTR_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q    <= swa_pkg::WINDOW_RESET;
      total_q <= '0;
      fill_q  <= '0;
      wp_q    <= '0;
    end else begin
      wl_q    <= wl_d;
      total_q <= total_d;
      fill_q  <= fill_d;
      wp_q    <= wp_d;
    end
  end

  // Delay line with a registered read, bypassed when the slot is written now.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[wp_q] <= smp;
    end
    if (accept && (rd_addr_d == wp_q)) begin
      rd_q <= smp;
    end else begin
      rd_q <= mem[rd_addr_d];
    end
  end

  // Stage register feeding the divider chain.
  always_comb begin
    stage_ctrl_d = stage_ctrl_q;
    if (adv_i) begin
      stage_ctrl_d.valid = accept;
      stage_ctrl_d.neg   = total_new[SUM_BITS-1];
      stage_ctrl_d.warm  = warm_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_ctrl_q <= '0;
    end else begin
      stage_ctrl_q <= stage_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_total_q <= total_new;
      stage_fill_q  <= fill_new;
    end
  end

  assign window_length_o = wl_q;
  assign stage_ctrl_o    = stage_ctrl_q;
  assign stage_total_o   = stage_total_q;
  assign stage_fill_o    = stage_fill_q;

  `SWA_ASSERT_IMP(a_fill_le_len, 1'b1, fill_q <= len_cur, "fill count above window length")
  `SWA_ASSERT_NXT(a_last_clears, accept && in_data_i.last_sample, (fill_q == '0) && (total_q == '0), "sequence end did not clear the window")
  `SWA_ASSERT_IMP(a_stage_fill, stage_ctrl_q.valid, stage_fill_q != '0, "divisor of zero entered the chain")

endmodule

`default_nettype wire

// ===== rtl/swa_div_cell.sv =====
`default_nettype none
`include "sliding_window_average_assert.svh"

module swa_div_cell #(
  parameter int DEN_BITS = 8,
  parameter int ACC_BITS = 24
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  swa_pkg::div_ctrl_t        ctrl_i,
  input  wire [DEN_BITS-1:0]        rem_i,
  input  wire [ACC_BITS-1:0]        acc_i,
  input  wire [DEN_BITS-1:0]        den_i,
  output swa_pkg::div_ctrl_t        ctrl_o,
  output logic [DEN_BITS-1:0]       rem_o,
  output logic [ACC_BITS-1:0]       acc_o,
  output logic [DEN_BITS-1:0]       den_o
);

  swa_pkg::div_ctrl_t   ctrl_q;
  logic [DEN_BITS-1:0]  rem_q, rem_d;
  logic [ACC_BITS-1:0]  acc_q, acc_d;
  logic [DEN_BITS-1:0]  den_q;
  logic [DEN_BITS:0]    trial;
  logic                 qbit;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_i, acc_i[ACC_BITS-1]};
    qbit  = (trial >= {1'b0, den_i});
    if (qbit) begin
      rem_d = DEN_BITS'(trial - {1'b0, den_i});
    end else begin
      rem_d = trial[DEN_BITS-1:0];
    end
    acc_d = {acc_i[ACC_BITS-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      acc_q <= acc_d;
      den_q <= den_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign acc_o  = acc_q;
  assign den_o  = den_q;

  `SWA_ASSERT_IMP(a_rem_lt_den, ctrl_q.valid, rem_q < den_q, "partial remainder not below divisor")

endmodule

`default_nettype wire

// ===== rtl/sliding_window_average.sv =====
// Moving-average filter over a stream of signed 24-bit samples.
// Input channel: in_valid_i / in_ready_o with in_data_i (sample and end-of-
// sequence flag). Output channel: out_valid_o / out_ready_i with out_data_o
// (mean of the window and a warm-up flag). One output beat per input beat.
// Throughput: one beat per cycle while the receiver keeps up.
// From input acceptance to out_valid_o a beat passes the stage register that
// takes the updated running sum and count, then a chain of 24 divider cells
// that resolve one quotient bit each, then the output register.
// The window length is written through the APB port at any address with
// paddr[2] clear; a write restarts the sequence. Reset sets the length to 100
// and clears the sum and count; the delay-line contents stay undefined and
// need no clearing pass. When the output register holds a beat that is not
// taken and another beat reaches the end of the chain, the whole chain holds
// and in_ready_o drops until out_ready_i returns.
`default_nettype none
`include "sliding_window_average_assert.svh"

module sliding_window_average #(
  parameter int MAX_WINDOW = 128
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  swa_pkg::in_beat_t                    in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output swa_pkg::out_beat_t                   out_data_o,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [swa_pkg::CFG_ADDR_BITS-1:0]     paddr,
  input  wire [31:0]                           pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int S        = swa_pkg::SAMPLE_BITS;
  localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
  localparam int PTR_BITS = $clog2(MAX_WINDOW);
  localparam int SUM_BITS = S + PTR_BITS;

  swa_pkg::cfg_wr_t             cfg;
  logic [swa_pkg::WL_BITS-1:0]  wl;
  logic                         reg_hit;
  logic                         chain_adv;

  swa_pkg::div_ctrl_t           ctrl [S+1];
  logic [CNT_BITS-1:0]          rem  [S+1];
  logic [S-1:0]                 acc  [S+1];
  logic [CNT_BITS-1:0]          den  [S+1];

  logic signed [SUM_BITS-1:0]   stage_total;
  logic [SUM_BITS-1:0]          mag;
  logic [S-1:0]                 quot;
  logic [S-1:0]                 quot_neg;

  logic                         out_valid_q, out_valid_d;
  swa_pkg::out_beat_t           out_data_q;
  logic                         out_load;

  // Register access.
  assign reg_hit   = (paddr[2] == swa_pkg::REG_WINDOW_LENGTH);
  assign cfg.wr    = psel && penable && pwrite && reg_hit;
  assign cfg.value = pwdata[swa_pkg::WL_BITS-1:0];
  assign pready    = 1'b1;
  assign prdata    = reg_hit ? {{(32 - swa_pkg::WL_BITS){1'b0}}, wl} : '0;

  // The chain holds only when its last beat cannot move into the output register.
  assign chain_adv  = !(ctrl[S].valid && out_valid_q && !out_ready_i);
  assign in_ready_o = chain_adv;

  swa_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .window_length_o (wl),
    .in_valid_i      (in_valid_i),
    .adv_i           (chain_adv),
    .in_data_i       (in_data_i),
    .stage_ctrl_o    (ctrl[0]),
    .stage_total_o   (stage_total),
    .stage_fill_o    (den[0])
  );

  // Magnitude of the sum; its high part is already below the divisor.
  assign mag    = stage_total[SUM_BITS-1] ? (~stage_total + SUM_BITS'(1)) : stage_total;
  assign rem[0] = CNT_BITS'(mag[SUM_BITS-1:S]);
  assign acc[0] = mag[S-1:0];

  // Divider chain, one quotient bit per cell.
  for (genvar g = 0; g < S; g++) begin : g_cell
    swa_div_cell #(
      .DEN_BITS (CNT_BITS),
      .ACC_BITS (S)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (chain_adv),
      .ctrl_i (ctrl[g]),
      .rem_i  (rem[g]),
      .acc_i  (acc[g]),
      .den_i  (den[g]),
      .ctrl_o (ctrl[g+1]),
      .rem_o  (rem[g+1]),
      .acc_o  (acc[g+1]),
      .den_o  (den[g+1])
    );
  end

  // Restore the sign so the mean truncates toward zero.
  assign quot     = acc[S];
  assign quot_neg = ~quot + {{(S - 1){1'b0}}, 1'b1};

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    if (!out_valid_q || out_ready_i) begin
      out_valid_d = ctrl[S].valid;
      out_load    = ctrl[S].valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.window_mean <= ctrl[S].neg ? quot_neg : quot;
      out_data_q.warming_up  <= ctrl[S].warm;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SWA_ASSERT_IMP(a_quot_range, ctrl[S].valid, quot <= {1'b1, {(S - 1){1'b0}}}, "quotient out of sample range")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int MAX_WINDOW  = 128;
  localparam int LATENCY     = swa_pkg::SAMPLE_BITS + 2;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;

  localparam logic [swa_pkg::CFG_ADDR_BITS-1:0] WINDOW_LENGTH_ADDR =
    {swa_pkg::REG_WINDOW_LENGTH, 2'b00};

  localparam logic signed [swa_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
    {1'b0, {(swa_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [swa_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
    {1'b1, {(swa_pkg::SAMPLE_BITS-1){1'b0}}};

  // Tracks the window of the filter and queues the mean expected for each accepted sample.
  class window_mean_tracker;
    logic signed [swa_pkg::SAMPLE_BITS-1:0] history [MAX_WINDOW];
    longint                                 total;
    int unsigned                            fill;
    int unsigned                            wr_ptr;
    logic [swa_pkg::WL_BITS-1:0]            window_len;
    swa_pkg::out_beat_t                     expected_means [$];
    int unsigned                            mismatches;

    function new();
      foreach (history[i]) history[i] = '0;
      total      = 0;
      fill       = 0;
      wr_ptr     = 0;
      window_len = swa_pkg::WINDOW_RESET;
      mismatches = 0;
    endfunction

    // A write of the length register restarts the sequence but keeps the pointer.
    function void set_window(logic [swa_pkg::WL_BITS-1:0] value);
      window_len = value;
      total      = 0;
      fill       = 0;
    endfunction

    // Zero behaves as one and anything above the delay line saturates.
    function int unsigned effective_len();
      if (window_len == 0) return 1;
      if (window_len > MAX_WINDOW) return MAX_WINDOW;
      return window_len;
    endfunction

    function void note_sample(swa_pkg::in_beat_t beat);
      int unsigned        len;
      longint             mean;
      swa_pkg::out_beat_t result;
      len = effective_len();
      // Once the window is full the oldest sample drops out of the sum.
      if (fill >= len) begin
        total -= longint'(history[(wr_ptr + MAX_WINDOW - len) % MAX_WINDOW]);
        fill = len;
      end else begin
        fill++;
      end
      history[wr_ptr] = beat.sample_value;
      total += longint'(beat.sample_value);
      wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
      // Signed division truncates toward zero.
      mean = total / longint'(fill);
      result.window_mean = mean[swa_pkg::SAMPLE_BITS-1:0];
      result.warming_up  = (fill < len);
      expected_means.push_back(result);
      // The end of a sequence clears the sum and count after its own result.
      if (beat.last_sample) begin
        total = 0;
        fill  = 0;
      end
    endfunction

    function void check_mean(swa_pkg::out_beat_t got);
      swa_pkg::out_beat_t want;
      if (expected_means.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected output beat: mean %0d warming_up %0b",
                   got.window_mean, got.warming_up);
        return;
      end
      want = expected_means.pop_front();
      if (got.window_mean !== want.window_mean || got.warming_up !== want.warming_up) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("output mismatch: mean expected %0d got %0d, warming_up expected %0b got %0b",
                   want.window_mean, got.window_mean, want.warming_up, got.warming_up);
      end
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni      = 1'b0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_ready_o;
  swa_pkg::in_beat_t                  in_data_i   = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  swa_pkg::out_beat_t                 out_data_o;
  logic                               psel        = 1'b0;
  logic                               penable     = 1'b0;
  logic                               pwrite      = 1'b0;
  logic [swa_pkg::CFG_ADDR_BITS-1:0]  paddr       = '0;
  logic [31:0]                        pwdata      = '0;
  logic [31:0]                        prdata;
  logic                               pready;

  int unsigned               send_idle_pct = 0;
  int unsigned               recv_idle_pct = 0;
  int unsigned               hold_requests = 0;
  int unsigned               cycle_count   = 0;

  window_mean_tracker        mean_check = new();

  sliding_window_average #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** sliding_window_average: FAILED **");
    $finish;
  end

  // Receiver: random back-pressure, with a long hold-off whenever one is requested.
  initial begin : receiver
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every output beat taken is checked against the oldest expected mean.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) mean_check.check_mean(out_data_o);
  end

  // Offers one input beat, with random idle cycles ahead of it, and waits for acceptance.
  task automatic send_beat(input logic signed [swa_pkg::SAMPLE_BITS-1:0] value,
                           input logic last);
    swa_pkg::in_beat_t beat;
    beat.sample_value = value;
    beat.last_sample  = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    mean_check.note_sample(beat);
  endtask

  // Stops sending and lets every expected beat come out, plus the pipeline depth.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (mean_check.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // APB write of the window length: setup cycle, then access until pready.
  task automatic write_window(input logic [swa_pkg::WL_BITS-1:0] length);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WINDOW_LENGTH_ADDR;
    pwdata  <= {(32 - swa_pkg::WL_BITS)'($urandom()), length};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mean_check.set_window(length);
  endtask

  // Random sequences, mostly well formed; a few are cut short by stray end flags.
  task automatic run_stream(input int unsigned n_items);
    int unsigned                            left;
    int unsigned                            seq_len;
    int unsigned                            mode;
    int unsigned                            k;
    logic signed [swa_pkg::SAMPLE_BITS-1:0] value;
    logic                                   last;
    left = n_items;
    while (left > 0) begin
      seq_len = $urandom_range(1, 2 * mean_check.effective_len() + 4);
      if (seq_len > left) seq_len = left;
      mode = $urandom_range(9);
      for (k = 0; k < seq_len; k++) begin
        case (mode)
          0: value = SAMPLE_MAX;
          1: value = SAMPLE_MIN;
          default: begin
            case ($urandom_range(9))
              0: value = SAMPLE_MAX;
              1: value = SAMPLE_MIN;
              2: value = swa_pkg::SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
              default: value = swa_pkg::SAMPLE_BITS'($urandom());
            endcase
          end
        endcase
        if (k == seq_len - 1) last = ($urandom_range(9) != 0);
        else last = (mode == 9) && ($urandom_range(15) == 0);
        send_beat(value, last);
      end
      left -= seq_len;
    end
  endtask

  initial begin : stimulus
    int unsigned                 phase;
    int unsigned                 step;
    int unsigned                 n_items;
    logic [swa_pkg::WL_BITS-1:0] length;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Window length as left by reset.
    send_beat(SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MIN, 1'b1);

    // Window of one: the mean is the sample itself.
    write_window(8'd1);
    send_beat('0, 1'b0);
    send_beat(-1, 1'b0);
    send_beat(SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MIN, 1'b1);

    // A length of zero behaves as one.
    write_window(8'd0);
    send_beat(5, 1'b0);
    send_beat(-5, 1'b1);

    // Short window: truncation toward zero, full window of the most negative sample,
    // then a new sequence left open so that the next write has to clear it.
    write_window(8'd3);
    send_beat(-7, 1'b0);
    send_beat('0, 1'b0);
    send_beat(1, 1'b0);
    send_beat(100, 1'b0);
    send_beat(SAMPLE_MIN, 1'b0);
    send_beat(SAMPLE_MIN, 1'b0);
    send_beat(SAMPLE_MIN, 1'b1);
    send_beat(-2, 1'b0);
    send_beat(-1, 1'b0);

    // Lengths beyond the delay line saturate.
    write_window(8'd255);
    send_beat(SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MAX, 1'b0);
    send_beat(-1, 1'b1);

    write_window(8'd128);
    send_beat(42, 1'b1);

    // Random part: three idle patterns, each with several window settings.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (step = 0; step < 4; step++) begin
        n_items = 45;
        case (step)
          0: length = $urandom_range(1, 12);
          1: length = $urandom_range(0, 255);
          2: begin
            length = (phase == 0) ? 8'd0 : (phase == 1) ? 8'd255 : 8'd128;
            if (phase != 0) n_items = 160;
          end
          default: length = $urandom_range(2, 40);
        endcase
        write_window(length);
        if (phase == 1 && step == 0) begin
          // Sender waits mid-stream until every result is out.
          run_stream(20);
          drain_results();
          run_stream(25);
        end else begin
          // In phase 2, step 0: long receiver hold-off so the pipeline fills and stalls the input.
          if (phase == 2 && step == 0) hold_requests <= hold_requests + 1;
          run_stream(n_items);
        end
      end
    end

    drain_results();
    if (mean_check.mismatches == 0 && mean_check.pending() == 0) begin
      $display("** sliding_window_average: PASSED **");
    end else begin
      $display("** sliding_window_average: FAILED **");
    end
    $finish;
  end

endmodule
